// ===== hw/rtl/rau_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Operand and magnitude widths, payload structs, operation codes and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

    // Operand width of each numerator and denominator
    localparam int OPERAND_WIDTH = 16;
    // Magnitude of one operand, wide enough to hold 2**(OPERAND_WIDTH-1)
    localparam int MAG_W         = OPERAND_WIDTH + 1;
    // Magnitude of a product or of a sum of two products
    localparam int MW            = 2 * MAG_W;
    // Shift and bit-count width over a full magnitude
    localparam int SH_W          = $clog2(MW + 1);
    // Result field widths
    localparam int RES_NUM_W     = 33;
    localparam int RES_DEN_W     = 31;
    // Common width for negating and truncating the result
    localparam int EXT_W         = (MW > RES_NUM_W) ? MW : RES_NUM_W;

    // Status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_DIVZ = 1'b1;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // Which product the shared multiplier forms
    typedef enum logic [1:0] {
        MSEL_T0,
        MSEL_T1,
        MSEL_DEN
    } mul_sel_t;

    // Which kind of result goes to the output register
    typedef enum logic [1:0] {
        RES_NORMAL,
        RES_ZERO,
        RES_DIVZ
    } res_kind_t;

    typedef struct packed {
        op_t                              op;
        logic signed [OPERAND_WIDTH-1:0]  a_num;
        logic signed [OPERAND_WIDTH-1:0]  a_den;
        logic signed [OPERAND_WIDTH-1:0]  b_num;
        logic signed [OPERAND_WIDTH-1:0]  b_den;
    } in_t;

    typedef struct packed {
        logic signed [RES_NUM_W-1:0]  res_num;
        logic [RES_DEN_W-1:0]         res_den;
        logic                         status;
    } out_t;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        mul_sel_t   mul_sel;
        logic       combine;
        logic       gcd_init;
        logic       gcd_step;
        logic       div_start;
        logic       res_load;
        res_kind_t  res_kind;
    } cmd_t;

    typedef struct packed {
        logic  num_zero;
        logic  den_zero;
        logic  gcd_done;
        logic  div_done;
    } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rau_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rau_div: bit-serial restoring divider
// Divides an MW-bit dividend by an MW-bit divisor, one quotient bit per
// cycle. The quotient holds after done until the next start.
// ----------------------------------------------------------------------------
module rau_div (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [rau_pkg::MW-1:0] dividend,
    input  wire logic [rau_pkg::MW-1:0] divisor,
    output logic                       busy,
    output logic                       done,
    output logic [rau_pkg::MW-1:0]     quotient
);
    import rau_pkg::*;

    logic [MW-1:0]   quo_reg;
    logic [MW-1:0]   rem_reg;
    logic [MW-1:0]   dsr_reg;
    logic [SH_W-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [MW:0]     trial;
    logic [MW:0]     trial_sub;
    logic            take;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        trial     = {rem_reg, quo_reg[MW-1]};
        trial_sub = trial - {1'b0, dsr_reg};
        take      = (trial >= {1'b0, dsr_reg});
    end

    // Control: count down one bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= SH_W'(MW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - SH_W'(1);
                if (cnt_reg == SH_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[MW-2:0], take};
            rem_reg <= take ? trial_sub[MW-1:0] : trial[MW-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("divider done without a running division");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg)
        else $error("divider did not start");

endmodule
`default_nettype wire

// ===== hw/rtl/rau_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rau_datapath: operand registers, shared multiplier, GCD and dividers
// Forms the raw fraction by cross multiplication, reduces it by the binary
// GCD and two serial divisions, and holds the result word.
// ----------------------------------------------------------------------------
module rau_datapath (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire rau_pkg::in_t   s_data,
    input  wire rau_pkg::cmd_t  cmd,
    output rau_pkg::sts_t       sts,
    output rau_pkg::out_t       m_data
);
    import rau_pkg::*;

    // Operand registers in sign and magnitude
    op_t             op_reg;
    logic [MAG_W-1:0] an_mag_reg, ad_mag_reg, bn_mag_reg, bd_mag_reg;
    logic            an_neg_reg, ad_neg_reg, bn_neg_reg, bd_neg_reg;

    // Product and fraction registers
    logic [MW-1:0]   t0_mag_reg, t1_mag_reg, den_mag_reg, num_mag_reg;
    logic            t0_neg_reg, t1_neg_reg, den_neg_reg, num_neg_reg;

    // GCD registers
    logic [MW-1:0]   u_reg, v_reg;
    logic [SH_W-1:0] k_reg;

    out_t            res_reg;

    // Split a two's complement operand into sign and magnitude
    function automatic logic [MAG_W-1:0] mag_of(input logic [OPERAND_WIDTH-1:0] v);
        logic [MAG_W-1:0] sx;
        sx = {v[OPERAND_WIDTH-1], v};
        return v[OPERAND_WIDTH-1] ? (MAG_W'(0) - sx) : sx;
    endfunction

    // Select multiplier operands for the current product
    logic [MAG_W-1:0] x_mag, y_mag;
    logic             x_neg, y_neg;
    logic [MW-1:0]    prod;
    logic             prod_neg;

    always_comb begin
        unique case (cmd.mul_sel)
            MSEL_T0: begin
                x_mag = an_mag_reg;
                x_neg = an_neg_reg;
                y_mag = (op_reg == OP_MUL) ? bn_mag_reg : bd_mag_reg;
                y_neg = (op_reg == OP_MUL) ? bn_neg_reg : bd_neg_reg;
            end
            MSEL_T1: begin
                x_mag = bn_mag_reg;
                x_neg = bn_neg_reg;
                y_mag = ad_mag_reg;
                y_neg = ad_neg_reg;
            end
            default: begin
                x_mag = ad_mag_reg;
                x_neg = ad_neg_reg;
                y_mag = (op_reg == OP_DIV) ? bn_mag_reg : bd_mag_reg;
                y_neg = (op_reg == OP_DIV) ? bn_neg_reg : bd_neg_reg;
            end
        endcase
        prod     = x_mag * y_mag;
        prod_neg = x_neg ^ y_neg;
    end

    // Signed-magnitude sum of the two numerator terms
    logic [MW-1:0] sum_mag;
    logic          sum_neg;

    always_comb begin
        if (t0_neg_reg == t1_neg_reg) begin
            sum_mag = t0_mag_reg + t1_mag_reg;
            sum_neg = t0_neg_reg;
        end else if (t0_mag_reg >= t1_mag_reg) begin
            sum_mag = t0_mag_reg - t1_mag_reg;
            sum_neg = t0_neg_reg;
        end else begin
            sum_mag = t1_mag_reg - t0_mag_reg;
            sum_neg = t1_neg_reg;
        end
    end

    // Binary GCD step
    logic [MW-1:0]   u_next, v_next;
    logic [SH_W-1:0] k_next;
    logic [MW-1:0]   d_uv, d_vu;

    always_comb begin
        d_uv   = u_reg - v_reg;
        d_vu   = v_reg - u_reg;
        u_next = u_reg;
        v_next = v_reg;
        k_next = k_reg;
        if (!u_reg[0] && !v_reg[0]) begin
            u_next = u_reg >> 1;
            v_next = v_reg >> 1;
            k_next = k_reg + SH_W'(1);
        end else if (!u_reg[0]) begin
            u_next = u_reg >> 1;
        end else if (!v_reg[0]) begin
            v_next = v_reg >> 1;
        end else if (u_reg >= v_reg) begin
            u_next = d_uv >> 1;
        end else begin
            v_next = d_vu >> 1;
        end
    end

    // Capture operands
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= s_data.op;
            an_mag_reg <= mag_of(s_data.a_num);
            ad_mag_reg <= mag_of(s_data.a_den);
            bn_mag_reg <= mag_of(s_data.b_num);
            bd_mag_reg <= mag_of(s_data.b_den);
            an_neg_reg <= s_data.a_num[OPERAND_WIDTH-1];
            ad_neg_reg <= s_data.a_den[OPERAND_WIDTH-1];
            bn_neg_reg <= s_data.b_num[OPERAND_WIDTH-1];
            bd_neg_reg <= s_data.b_den[OPERAND_WIDTH-1];
        end
    end

    // Store products; the second term exists only for add and subtract
    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            unique case (cmd.mul_sel)
                MSEL_T0: begin
                    t0_mag_reg <= prod;
                    t0_neg_reg <= prod_neg;
                end
                MSEL_T1: begin
                    t1_mag_reg <= (op_reg == OP_ADD || op_reg == OP_SUB) ? prod : '0;
                    t1_neg_reg <= (op_reg == OP_SUB) ? !prod_neg : prod_neg;
                end
                default: begin
                    den_mag_reg <= prod;
                    den_neg_reg <= prod_neg;
                end
            endcase
        end
        if (cmd.combine) begin
            num_mag_reg <= sum_mag;
            num_neg_reg <= sum_neg;
        end
    end

    // Run the GCD
    always_ff @(posedge aclk) begin
        if (cmd.gcd_init) begin
            u_reg <= num_mag_reg;
            v_reg <= den_mag_reg;
            k_reg <= '0;
        end else if (cmd.gcd_step) begin
            u_reg <= u_next;
            v_reg <= v_next;
            k_reg <= k_next;
        end
    end

    // Divide both magnitudes by the GCD: drop the common power of two first
    logic [MW-1:0] num_q, den_q;
    logic          num_busy, den_busy, num_done, den_done;

    rau_div u_div_num (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (num_mag_reg >> k_reg),
        .divisor  (v_reg),
        .busy     (num_busy),
        .done     (num_done),
        .quotient (num_q)
    );

    rau_div u_div_den (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (den_mag_reg >> k_reg),
        .divisor  (v_reg),
        .busy     (den_busy),
        .done     (den_done),
        .quotient (den_q)
    );

    // Result word: move the sign onto the numerator
    logic [EXT_W-1:0] nm_ext, dm_ext, n_ext;

    always_comb begin
        nm_ext = EXT_W'(num_q);
        dm_ext = EXT_W'(den_q);
        n_ext  = (num_neg_reg ^ den_neg_reg) ? (EXT_W'(0) - nm_ext) : nm_ext;
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            unique case (cmd.res_kind)
                RES_ZERO: begin
                    res_reg.res_num <= '0;
                    res_reg.res_den <= RES_DEN_W'(1);
                    res_reg.status  <= STATUS_OK;
                end
                RES_DIVZ: begin
                    res_reg.res_num <= '0;
                    res_reg.res_den <= '0;
                    res_reg.status  <= STATUS_DIVZ;
                end
                default: begin
                    res_reg.res_num <= $signed(n_ext[RES_NUM_W-1:0]);
                    res_reg.res_den <= dm_ext[RES_DEN_W-1:0];
                    res_reg.status  <= STATUS_OK;
                end
            endcase
        end
    end

    assign m_data       = res_reg;
    assign sts.num_zero = (num_mag_reg == '0);
    assign sts.den_zero = (den_mag_reg == '0);
    assign sts.gcd_done = (u_reg == '0);
    assign sts.div_done = num_done && den_done && !num_busy && !den_busy;

endmodule
`default_nettype wire

// ===== hw/rtl/rau_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rau_ctrl: sequencing state machine of the rational arithmetic unit
// Steps the datapath through multiply, combine, GCD and divide phases and
// owns both channel handshakes.
// ----------------------------------------------------------------------------
module rau_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  wire logic           m_ready,
    input  wire rau_pkg::sts_t  sts,
    output rau_pkg::cmd_t       cmd
);
    import rau_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_T0,
        S_MUL_T1,
        S_MUL_DEN,
        S_COMBINE,
        S_CHECK,
        S_GCD,
        S_DIV_START,
        S_DIV_WAIT,
        S_FINISH
    } state_t;

    state_t    state_reg, state_next;
    logic      m_valid_reg, m_valid_next;
    res_kind_t res_kind_reg, res_kind_next;
    logic      out_free;

    assign out_free = !m_valid_reg || m_ready;

    // Decode commands and next state
    always_comb begin
        cmd           = '0;
        cmd.mul_sel   = MSEL_T0;
        cmd.res_kind  = res_kind_reg;
        state_next    = state_reg;
        res_kind_next = res_kind_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL_T0;
                end
            end
            S_MUL_T0: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_T0;
                state_next  = S_MUL_T1;
            end
            S_MUL_T1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_T1;
                state_next  = S_MUL_DEN;
            end
            S_MUL_DEN: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_DEN;
                state_next  = S_COMBINE;
            end
            S_COMBINE: begin
                cmd.combine = 1'b1;
                state_next  = S_CHECK;
            end
            S_CHECK: begin
                if (sts.den_zero) begin
                    res_kind_next = RES_DIVZ;
                    state_next    = S_FINISH;
                end else if (sts.num_zero) begin
                    res_kind_next = RES_ZERO;
                    state_next    = S_FINISH;
                end else begin
                    cmd.gcd_init = 1'b1;
                    state_next   = S_GCD;
                end
            end
            S_GCD: begin
                if (sts.gcd_done) begin
                    state_next = S_DIV_START;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (sts.div_done) begin
                    res_kind_next = RES_NORMAL;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH: begin
                // Hold until the output register can take the word
                if (out_free) begin
                    cmd.res_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            res_kind_reg <= RES_NORMAL;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            res_kind_reg <= res_kind_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |-> out_free)
        else $error("result word overwritten before it was taken");
    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> state_reg == S_DIV_WAIT)
        else $error("divider finished outside the wait phase");
    a_divz_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK) && sts.den_zero |=>
            (state_reg == S_FINISH) && (res_kind_reg == RES_DIVZ))
        else $error("zero denominator not flagged");
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> s_valid && (state_reg == S_IDLE))
        else $error("operands captured without an accepted word");

endmodule
`default_nettype wire

// ===== hw/rtl/rational_arithmetic_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: add, subtract, multiply or divide two fractions
// The input channel (s_valid/s_ready/s_data) takes one word: an operation
// code and two signed fractions. The result channel (m_valid/m_ready/m_data)
// returns one word per input: the numerator carrying the sign, a positive
// denominator reduced to lowest terms, and a status bit that flags a zero
// raw denominator (numerator and denominator then read zero). A zero
// numerator gives 0/1.
// One word is worked on at a time; s_ready is high only while idle.
// After acceptance the three cross products are formed, the numerator is
// combined and the zero cases are checked; these finish directly. Otherwise
// the binary GCD runs and then the two serial dividers, which work on
// MW = 2*OPERAND_WIDTH+2 (34) bit magnitudes.
// The three cross products share one multiplier, formed one after another.
// The result sits in an output register: the next word is accepted while it
// waits, and its own result is held back until the register is free.
// Reset (aresetn low, synchronous) returns to idle and drops m_valid.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire rau_pkg::in_t   s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output rau_pkg::out_t       m_data
);
    import rau_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rau_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rau_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire
